>>> rtl/svf_pkg.sv
`timescale 1ns / 1ps
// Package for the value splitter: search limit, masks, seed start and the
// sequencer state type. No dependencies.
package svf_pkg;

    localparam int unsigned FactorLimit = 65535;

    localparam logic [15:0] FACTOR_LIMIT = 16'(FactorLimit);
    localparam logic [15:0] MASK16       = 16'hffff;
    localparam logic [15:0] SEED_START   = 16'h8000;
    localparam logic [3:0]  SEED_SHIFT   = 4'd15;    // log2 of SEED_START
    localparam logic [15:0] MIN_DIVISOR  = 16'd2;
    localparam logic [3:0]  DIV_LAST     = 4'd15;    // last divider step

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_SEED   = 5'b00010,
        ST_CHECK  = 5'b00100,
        ST_DIV    = 5'b01000,
        ST_FINISH = 5'b10000
    } svf_state_t;

endpackage

>>> rtl/svf_ifs.sv
`timescale 1ns / 1ps
// Handshake channels of the value splitter: input word, result word and
// configuration write. Depends on nothing but the channel widths below.
interface svf_item_if;
    logic        valid;
    logic        ready;
    logic [31:0] value;

    modport source (output valid, output value, input ready);
    modport sink (input valid, input value, output ready);
endinterface

interface svf_result_if;
    logic        valid;
    logic        ready;
    logic [15:0] quotient_factor;
    logic [15:0] divisor_factor;
    logic [15:0] remainder;
    logic [15:0] iterations;
    logic        no_fit;

    modport source (output valid, output quotient_factor, output divisor_factor,
                    output remainder, output iterations, output no_fit, input ready);
    modport sink (input valid, input quotient_factor, input divisor_factor,
                  input remainder, input iterations, input no_fit, output ready);
endinterface

interface svf_cfg_if;
    logic valid;
    logic ready;
    logic search_mode;

    modport source (output valid, output search_mode, input ready);
    modport sink (input valid, input search_mode, output ready);
endinterface

>>> rtl/split_value_into_two_factors.sv
`timescale 1ns / 1ps
// Top level of the value splitter: sequencer, seed search and a bit-serial
// 32/16 divider. Uses svf_pkg and the channels in svf_ifs.sv.

// Splits a 32-bit value into a 16-bit quotient and a 16-bit divisor by trying
// divisors upward from 2 (or from a seed in mode 1) and keeping the least
// remainder among those whose quotient fits 16 bits; the first exact fit ends
// the search. One word is worked at a time and the input is not ready until
// the search is over. A candidate whose quotient is too wide takes a single
// check; one that fits takes a check plus 16 steps of the shared one-bit
// restoring divider, so a full search tries at most 65533 candidates, after
// the seed search in mode 1. The small-value shortcut of mode 1 skips the
// search. A finished result waits in an output register, so the
// next word can be accepted before the result is taken.
module split_value_into_two_factors (
    input  logic                 clk,
    input  logic                 rst_n,
    svf_cfg_if.sink              cfg,
    svf_item_if.sink             item,
    svf_result_if.source         result
);

    svf_pkg::svf_state_t state_reg, state_next;
    logic        mode_reg, mode_next;
    logic        out_valid_reg, out_valid_next;

    logic [31:0] value_reg, value_next;
    logic [15:0] x_reg, x_next;
    logic [3:0]  k_reg, k_next;
    logic [15:0] d_reg, d_next;
    logic [15:0] cand_reg, cand_next;
    logic [15:0] count_reg, count_next;
    logic [15:0] rem_reg, rem_next;
    logic [15:0] quo_reg, quo_next;
    logic [3:0]  step_reg, step_next;
    logic        found_reg, found_next;
    logic [15:0] best_rem_reg, best_rem_next;
    logic [15:0] best_div_reg, best_div_next;
    logic [15:0] best_quo_reg, best_quo_next;
    logic [15:0] oq_reg, oq_next;
    logic [15:0] od_reg, od_next;
    logic [15:0] or_reg, or_next;
    logic [15:0] oi_reg, oi_next;
    logic        onf_reg, onf_next;

    logic [31:0] seed_shifted;
    logic [15:0] seed_pick;
    logic [15:0] seed_start;
    logic [16:0] div_trial;
    logic [16:0] div_diff;
    logic        div_ge;
    logic [15:0] rem_step;
    logic [15:0] quo_step;
    logic        better;

    assign cfg.ready     = 1'b1;
    assign item.ready    = (state_reg == svf_pkg::ST_IDLE);
    assign result.valid  = out_valid_reg;
    assign result.quotient_factor = oq_reg;
    assign result.divisor_factor  = od_reg;
    assign result.remainder       = or_reg;
    assign result.iterations      = oi_reg;
    assign result.no_fit          = onf_reg;

    // division by a power of two is a shift
    assign seed_shifted = value_reg >> k_reg;
    assign seed_pick    = (d_reg < x_reg) ? x_reg : d_reg;
    assign seed_start   = (seed_pick < svf_pkg::MIN_DIVISOR) ? svf_pkg::MIN_DIVISOR
                                                              : seed_pick;

    // one restoring step; partial remainder stays below the divisor
    assign div_trial = {rem_reg, quo_reg[15]};
    assign div_diff  = div_trial - {1'b0, cand_reg};
    assign div_ge    = (div_trial >= {1'b0, cand_reg});
    assign rem_step  = div_ge ? div_diff[15:0] : div_trial[15:0];
    assign quo_step  = {quo_reg[14:0], div_ge};
    assign better    = !found_reg || (rem_step < best_rem_reg);

    always_comb
    begin
        state_next     = state_reg;
        mode_next      = mode_reg;
        out_valid_next = out_valid_reg && !result.ready;
        value_next     = value_reg;
        x_next         = x_reg;
        k_next         = k_reg;
        d_next         = d_reg;
        cand_next      = cand_reg;
        count_next     = count_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        step_next      = step_reg;
        found_next     = found_reg;
        best_rem_next  = best_rem_reg;
        best_div_next  = best_div_reg;
        best_quo_next  = best_quo_reg;
        oq_next        = oq_reg;
        od_next        = od_reg;
        or_next        = or_reg;
        oi_next        = oi_reg;
        onf_next       = onf_reg;

        if (cfg.valid)
        begin
            mode_next = cfg.search_mode;
        end

        case (state_reg)
            svf_pkg::ST_IDLE:
            begin
                if (item.valid)
                begin
                    value_next = item.value;
                    count_next = '0;
                    x_next     = svf_pkg::SEED_START;
                    k_next     = svf_pkg::SEED_SHIFT;
                    d_next     = '0;
                    cand_next  = svf_pkg::MIN_DIVISOR;
                    if (mode_reg && (item.value < {16'd0, svf_pkg::MASK16}))
                    begin
                        // small value: value * 1
                        found_next    = 1'b1;
                        best_quo_next = 16'd1;
                        best_div_next = item.value[15:0];
                        best_rem_next = '0;
                        state_next    = svf_pkg::ST_FINISH;
                    end
                    else
                    begin
                        // defaults give the no-fit answer
                        found_next    = 1'b0;
                        best_quo_next = item.value[16:1];
                        best_div_next = svf_pkg::MIN_DIVISOR;
                        best_rem_next = svf_pkg::MASK16;
                        state_next    = mode_reg ? svf_pkg::ST_SEED : svf_pkg::ST_CHECK;
                    end
                end
            end

            svf_pkg::ST_SEED:
            begin
                if ((d_reg >= svf_pkg::MIN_DIVISOR) || (x_reg == '0))
                begin
                    cand_next  = seed_start;
                    state_next = svf_pkg::ST_CHECK;
                end
                else
                begin
                    d_next = seed_shifted[15:0];
                    x_next = x_reg >> 1;
                    k_next = k_reg - 4'd1;
                end
            end

            svf_pkg::ST_CHECK:
            begin
                if (cand_reg >= svf_pkg::FACTOR_LIMIT)
                begin
                    state_next = svf_pkg::ST_FINISH;
                end
                else
                begin
                    count_next = count_reg + 16'd1;
                    // quotient fits 16 bits exactly when the high half is below the candidate
                    if (value_reg[31:16] < cand_reg)
                    begin
                        rem_next   = value_reg[31:16];
                        quo_next   = value_reg[15:0];
                        step_next  = '0;
                        state_next = svf_pkg::ST_DIV;
                    end
                    else
                    begin
                        cand_next = cand_reg + 16'd1;
                    end
                end
            end

            svf_pkg::ST_DIV:
            begin
                rem_next  = rem_step;
                quo_next  = quo_step;
                step_next = step_reg + 4'd1;
                if (step_reg == svf_pkg::DIV_LAST)
                begin
                    found_next = 1'b1;
                    if (better)
                    begin
                        best_rem_next = rem_step;
                        best_div_next = cand_reg;
                        best_quo_next = quo_step;
                    end
                    if (rem_step == '0)
                    begin
                        state_next = svf_pkg::ST_FINISH;
                    end
                    else
                    begin
                        cand_next  = cand_reg + 16'd1;
                        state_next = svf_pkg::ST_CHECK;
                    end
                end
            end

            svf_pkg::ST_FINISH:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    oq_next        = best_quo_reg;
                    od_next        = best_div_reg;
                    or_next        = best_rem_reg;
                    oi_next        = count_reg;
                    onf_next       = !found_reg;
                    out_valid_next = 1'b1;
                    state_next     = svf_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = svf_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= svf_pkg::ST_IDLE;
            mode_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            mode_reg      <= mode_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg    <= value_next;
        x_reg        <= x_next;
        k_reg        <= k_next;
        d_reg        <= d_next;
        cand_reg     <= cand_next;
        count_reg    <= count_next;
        rem_reg      <= rem_next;
        quo_reg      <= quo_next;
        step_reg     <= step_next;
        found_reg    <= found_next;
        best_rem_reg <= best_rem_next;
        best_div_reg <= best_div_next;
        best_quo_reg <= best_quo_next;
        oq_reg       <= oq_next;
        od_reg       <= od_next;
        or_reg       <= or_next;
        oi_reg       <= oi_next;
        onf_reg      <= onf_next;
    end

endmodule
